// ===== hw/rtl/motion_vector_clip_wrap_defines.svh =====
// Assertion macros used by the checker file of the motion vector clip block.
`ifndef MOTION_VECTOR_CLIP_WRAP_DEFINES_SVH
`define MOTION_VECTOR_CLIP_WRAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mvc_pkg.sv =====
// Package: widths, register map, reset values and config type of the MV clip block.
package mvc_pkg;

    localparam int MV_IN_W   = 18;
    localparam int MV_OUT_W  = 20;
    localparam int POS_W     = 14;
    localparam int BW_W      = 8;
    localparam int PIC_W     = 15;
    localparam int CTU_W     = 8;
    localparam int BND_W     = 17;    // signed bound in whole samples
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam int WIN_MARGIN = 8;
    localparam int OUT_HI     = 524287;
    localparam int OUT_LO     = -524288;

    localparam logic [PIC_W-1:0] RST_PIC_WIDTH   = PIC_W'(1920);
    localparam logic [PIC_W-1:0] RST_PIC_HEIGHT  = PIC_W'(1080);
    localparam logic [CTU_W-1:0] RST_CTU_SIZE    = CTU_W'(128);
    localparam logic             RST_WRAP_ENABLE = 1'b0;
    localparam logic [PIC_W-1:0] RST_WRAP_OFFSET = '0;

    typedef enum logic [2:0] {
        REG_PIC_WIDTH   = 3'd0,
        REG_PIC_HEIGHT  = 3'd1,
        REG_CTU_SIZE    = 3'd2,
        REG_WRAP_ENABLE = 3'd3,
        REG_WRAP_OFFSET = 3'd4
    } t_reg_addr;

    typedef struct packed {
        logic [PIC_W-1:0] pic_width;
        logic [PIC_W-1:0] pic_height;
        logic [CTU_W-1:0] ctu_size;
        logic             wrap_enable;
        logic [PIC_W-1:0] wrap_offset;
    } t_cfg;

endpackage

// ===== hw/rtl/mvc_if.sv =====
// Valid/ready word channels: block descriptor in, clipped vector out.
interface mvc_in_if;
    import mvc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MV_IN_W-1:0]  in_mv_hor;
    logic signed [MV_IN_W-1:0]  in_mv_ver;
    logic        [POS_W-1:0]    pos_x;
    logic        [POS_W-1:0]    pos_y;
    logic        [BW_W-1:0]     block_width;
    logic                       subpic_as_pic;
    logic        [POS_W-1:0]    sub_left;
    logic        [POS_W-1:0]    sub_right;
    logic        [POS_W-1:0]    sub_top;
    logic        [POS_W-1:0]    sub_bottom;

    modport source (
        output valid, in_mv_hor, in_mv_ver, pos_x, pos_y, block_width,
               subpic_as_pic, sub_left, sub_right, sub_top, sub_bottom,
        input  ready
    );
    modport sink (
        input  valid, in_mv_hor, in_mv_ver, pos_x, pos_y, block_width,
               subpic_as_pic, sub_left, sub_right, sub_top, sub_bottom,
        output ready
    );
endinterface

interface mvc_out_if;
    import mvc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MV_OUT_W-1:0] out_mv_hor;
    logic signed [MV_OUT_W-1:0] out_mv_ver;
    logic                       wrap_ref;

    modport source (output valid, out_mv_hor, out_mv_ver, wrap_ref, input ready);
    modport sink   (input valid, out_mv_hor, out_mv_ver, wrap_ref, output ready);
endinterface

// ===== hw/rtl/motion_vector_clip_wrap.sv =====
// Motion vector clipper: top level with register file and three-stage clip pipeline.
//
// Clamps one motion vector per word (MV_FRAC_BITS fraction bits) so that the
// referenced block stays inside a window: the picture, or the subpicture when
// subpic_as_pic is set, reaching 7 samples plus one CTU past the low edge and
// 8 samples past the last sample. With wrap_enable set, subpictures are ignored,
// the horizontal maximum grows by ctu_size - block_width, and a horizontal
// component outside the window is shifted by wrap_offset samples toward it,
// clamped, and reported with wrap_ref = 0. Outputs are 20-bit signed and
// saturate at the ends of that range.
// Throughput is one word per clock while o_out is not stalled. There are three
// register stages (window edges, then scaling and wrap shift, then clamp into
// the output register). Each stage holds its word under back-pressure and a
// stage frees as soon as the one after it moves, so the pipeline keeps taking
// words until all three stages are full and stalled.
// Registers (APB, byte address 4*index): 0 pic_width, 1 pic_height,
// 2 ctu_size, 3 wrap_enable, 4 wrap_offset. Write them only with no word in
// flight.
module motion_vector_clip_wrap #(
    parameter int MV_FRAC_BITS = 4     // 0..6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mvc_in_if.sink                      i_in,
    mvc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvc_pkg::APB_AW-1:0]  paddr,
    input  logic [mvc_pkg::APB_DW-1:0]  pwdata,
    output logic [mvc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import mvc_pkg::*;

    // Working width after scaling: bounds and shifted vector plus guard bits,
    // never narrower than the output plus one so saturation sees overflow.
    localparam int CW = (BND_W + MV_FRAC_BITS + 2 > MV_OUT_W + 1)
                      ? (BND_W + MV_FRAC_BITS + 2) : (MV_OUT_W + 1);

    t_cfg w_cfg;

    // stage 1 -> 2
    logic                      w_s1_valid, w_s1_ready, w_s1_wrap;
    logic signed [MV_IN_W-1:0] w_s1_mv_hor, w_s1_mv_ver;
    logic signed [BND_W-1:0]   w_s1_hmax, w_s1_hmin, w_s1_vmax, w_s1_vmin;

    // stage 2 -> 3
    logic                      w_s2_valid, w_s2_ready, w_s2_wrap_ref;
    logic signed [CW-1:0]      w_s2_hor, w_s2_ver;
    logic signed [CW-1:0]      w_s2_hmax, w_s2_hmin, w_s2_vmax, w_s2_vmin;

    mvc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // window edges in whole samples
    mvc_bound u_bound (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_mv_hor        (i_in.in_mv_hor),
        .i_mv_ver        (i_in.in_mv_ver),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_block_width   (i_in.block_width),
        .i_subpic_as_pic (i_in.subpic_as_pic),
        .i_sub_left      (i_in.sub_left),
        .i_sub_right     (i_in.sub_right),
        .i_sub_top       (i_in.sub_top),
        .i_sub_bottom    (i_in.sub_bottom),
        .o_valid         (w_s1_valid),
        .i_ready         (w_s1_ready),
        .o_mv_hor        (w_s1_mv_hor),
        .o_mv_ver        (w_s1_mv_ver),
        .o_wrap          (w_s1_wrap),
        .o_hmax          (w_s1_hmax),
        .o_hmin          (w_s1_hmin),
        .o_vmax          (w_s1_vmax),
        .o_vmin          (w_s1_vmin)
    );

    // fractional scaling and wraparound shift
    mvc_wrap #(
        .MV_FRAC_BITS (MV_FRAC_BITS),
        .CW           (CW)
    ) u_wrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_s1_valid),
        .o_ready    (w_s1_ready),
        .i_mv_hor   (w_s1_mv_hor),
        .i_mv_ver   (w_s1_mv_ver),
        .i_wrap     (w_s1_wrap),
        .i_hmax     (w_s1_hmax),
        .i_hmin     (w_s1_hmin),
        .i_vmax     (w_s1_vmax),
        .i_vmin     (w_s1_vmin),
        .o_valid    (w_s2_valid),
        .i_ready    (w_s2_ready),
        .o_hor      (w_s2_hor),
        .o_ver      (w_s2_ver),
        .o_wrap_ref (w_s2_wrap_ref),
        .o_hmax     (w_s2_hmax),
        .o_hmin     (w_s2_hmin),
        .o_vmax     (w_s2_vmax),
        .o_vmin     (w_s2_vmin)
    );

    // final clamp; its register is the output register
    mvc_clamp #(
        .CW (CW)
    ) u_clamp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_s2_valid),
        .o_ready    (w_s2_ready),
        .i_hor      (w_s2_hor),
        .i_ver      (w_s2_ver),
        .i_wrap_ref (w_s2_wrap_ref),
        .i_hmax     (w_s2_hmax),
        .i_hmin     (w_s2_hmin),
        .i_vmax     (w_s2_vmax),
        .i_vmin     (w_s2_vmin),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_mv_hor   (o_out.out_mv_hor),
        .o_mv_ver   (o_out.out_mv_ver),
        .o_wrap_ref (o_out.wrap_ref)
    );
endmodule

// ===== hw/rtl/mvc_cfg.sv =====
// APB register file holding the picture, CTU and wraparound settings.
module mvc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvc_pkg::APB_AW-1:0]  paddr,
    input  logic [mvc_pkg::APB_DW-1:0]  pwdata,
    output logic [mvc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output mvc_pkg::t_cfg               o_cfg
);
    import mvc_pkg::*;

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_reg_addr w_addr;
    logic      w_wr;

    assign w_addr = t_reg_addr'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_addr)
                REG_PIC_WIDTH:   n_cfg.pic_width   = pwdata[PIC_W-1:0];
                REG_PIC_HEIGHT:  n_cfg.pic_height  = pwdata[PIC_W-1:0];
                REG_CTU_SIZE:    n_cfg.ctu_size    = pwdata[CTU_W-1:0];
                REG_WRAP_ENABLE: n_cfg.wrap_enable = pwdata[0];
                REG_WRAP_OFFSET: n_cfg.wrap_offset = pwdata[PIC_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_addr)
            REG_PIC_WIDTH:   prdata = APB_DW'(r_cfg.pic_width);
            REG_PIC_HEIGHT:  prdata = APB_DW'(r_cfg.pic_height);
            REG_CTU_SIZE:    prdata = APB_DW'(r_cfg.ctu_size);
            REG_WRAP_ENABLE: prdata = APB_DW'(r_cfg.wrap_enable);
            REG_WRAP_OFFSET: prdata = APB_DW'(r_cfg.wrap_offset);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pic_width   <= RST_PIC_WIDTH;
            r_cfg.pic_height  <= RST_PIC_HEIGHT;
            r_cfg.ctu_size    <= RST_CTU_SIZE;
            r_cfg.wrap_enable <= RST_WRAP_ENABLE;
            r_cfg.wrap_offset <= RST_WRAP_OFFSET;
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule

// ===== hw/rtl/mvc_bound.sv =====
// Stage 1: clamp window edges in whole samples for both components.
module mvc_bound (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mvc_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mvc_pkg::MV_IN_W-1:0]  i_mv_hor,
    input  logic signed [mvc_pkg::MV_IN_W-1:0]  i_mv_ver,
    input  logic        [mvc_pkg::POS_W-1:0]    i_pos_x,
    input  logic        [mvc_pkg::POS_W-1:0]    i_pos_y,
    input  logic        [mvc_pkg::BW_W-1:0]     i_block_width,
    input  logic                                i_subpic_as_pic,
    input  logic        [mvc_pkg::POS_W-1:0]    i_sub_left,
    input  logic        [mvc_pkg::POS_W-1:0]    i_sub_right,
    input  logic        [mvc_pkg::POS_W-1:0]    i_sub_top,
    input  logic        [mvc_pkg::POS_W-1:0]    i_sub_bottom,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mvc_pkg::MV_IN_W-1:0]  o_mv_hor,
    output logic signed [mvc_pkg::MV_IN_W-1:0]  o_mv_ver,
    output logic                                o_wrap,
    output logic signed [mvc_pkg::BND_W-1:0]    o_hmax,
    output logic signed [mvc_pkg::BND_W-1:0]    o_hmin,
    output logic signed [mvc_pkg::BND_W-1:0]    o_vmax,
    output logic signed [mvc_pkg::BND_W-1:0]    o_vmin
);
    import mvc_pkg::*;

    localparam logic signed [BND_W-1:0] MARGIN_M1 = BND_W'(WIN_MARGIN - 1);
    localparam logic signed [BND_W-1:0] ONE       = BND_W'(1);

    logic                     r_valid;
    logic signed [MV_IN_W-1:0] r_mv_hor, r_mv_ver;
    logic                     r_wrap;
    logic signed [BND_W-1:0]  r_hmax, r_hmin, r_vmax, r_vmin;

    logic                     w_adv;
    logic                     w_sub;
    logic signed [BND_W-1:0]  w_pw, w_ph, w_ctu, w_bw, w_px, w_py;
    logic signed [BND_W-1:0]  w_sl, w_sr, w_st, w_sb;
    logic signed [BND_W-1:0]  w_hi_x, w_lo_x, w_hi_y, w_lo_y;
    logic signed [BND_W-1:0]  n_hmax, n_hmin, n_vmax, n_vmin;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    // subpicture bounds only count with wraparound off
    assign w_sub = i_subpic_as_pic && !i_cfg.wrap_enable;

    assign w_pw  = $signed(BND_W'(i_cfg.pic_width));
    assign w_ph  = $signed(BND_W'(i_cfg.pic_height));
    assign w_ctu = $signed(BND_W'(i_cfg.ctu_size));
    assign w_bw  = $signed(BND_W'(i_block_width));
    assign w_px  = $signed(BND_W'(i_pos_x));
    assign w_py  = $signed(BND_W'(i_pos_y));
    assign w_sl  = $signed(BND_W'(i_sub_left));
    assign w_sr  = $signed(BND_W'(i_sub_right));
    assign w_st  = $signed(BND_W'(i_sub_top));
    assign w_sb  = $signed(BND_W'(i_sub_bottom));

    always_comb begin
        if (i_cfg.wrap_enable) begin
            w_hi_x = w_pw + w_ctu - w_bw;
        end else if (w_sub) begin
            w_hi_x = w_sr + ONE;
        end else begin
            w_hi_x = w_pw;
        end
        w_lo_x = w_sub ? w_sl : '0;
        w_hi_y = w_sub ? (w_sb + ONE) : w_ph;
        w_lo_y = w_sub ? w_st : '0;
        n_hmax = w_hi_x + MARGIN_M1 - w_px;
        n_hmin = w_lo_x - w_ctu - MARGIN_M1 - w_px;
        n_vmax = w_hi_y + MARGIN_M1 - w_py;
        n_vmin = w_lo_y - w_ctu - MARGIN_M1 - w_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_mv_hor <= i_mv_hor;
            r_mv_ver <= i_mv_ver;
            r_wrap   <= i_cfg.wrap_enable;
            r_hmax   <= n_hmax;
            r_hmin   <= n_hmin;
            r_vmax   <= n_vmax;
            r_vmin   <= n_vmin;
        end
    end

    assign o_valid  = r_valid;
    assign o_mv_hor = r_mv_hor;
    assign o_mv_ver = r_mv_ver;
    assign o_wrap   = r_wrap;
    assign o_hmax   = r_hmax;
    assign o_hmin   = r_hmin;
    assign o_vmax   = r_vmax;
    assign o_vmin   = r_vmin;
endmodule

// ===== hw/rtl/mvc_wrap.sv =====
// Stage 2: scale bounds to fractional units and apply the wraparound shift.
module mvc_wrap #(
    parameter int MV_FRAC_BITS = 4,
    parameter int CW           = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mvc_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mvc_pkg::MV_IN_W-1:0]  i_mv_hor,
    input  logic signed [mvc_pkg::MV_IN_W-1:0]  i_mv_ver,
    input  logic                                i_wrap,
    input  logic signed [mvc_pkg::BND_W-1:0]    i_hmax,
    input  logic signed [mvc_pkg::BND_W-1:0]    i_hmin,
    input  logic signed [mvc_pkg::BND_W-1:0]    i_vmax,
    input  logic signed [mvc_pkg::BND_W-1:0]    i_vmin,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [CW-1:0]                o_hor,
    output logic signed [CW-1:0]                o_ver,
    output logic                                o_wrap_ref,
    output logic signed [CW-1:0]                o_hmax,
    output logic signed [CW-1:0]                o_hmin,
    output logic signed [CW-1:0]                o_vmax,
    output logic signed [CW-1:0]                o_vmin
);
    import mvc_pkg::*;

    logic                 r_valid;
    logic signed [CW-1:0] r_hor, r_ver, r_hmax, r_hmin, r_vmax, r_vmin;
    logic                 r_wrap_ref;

    logic                 w_adv;
    logic signed [CW-1:0] w_mvh, w_off, w_hmax, w_hmin, w_vmax, w_vmin;
    logic                 w_above, w_below;
    logic signed [CW-1:0] n_hor;
    logic                 n_wrap_ref;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    assign w_mvh  = CW'(i_mv_hor);
    assign w_off  = $signed(CW'(i_cfg.wrap_offset)) <<< MV_FRAC_BITS;
    assign w_hmax = CW'(i_hmax) <<< MV_FRAC_BITS;
    assign w_hmin = CW'(i_hmin) <<< MV_FRAC_BITS;
    assign w_vmax = CW'(i_vmax) <<< MV_FRAC_BITS;
    assign w_vmin = CW'(i_vmin) <<< MV_FRAC_BITS;

    assign w_above = w_mvh > w_hmax;
    assign w_below = w_mvh < w_hmin;

    // Shifting back up after a downward wrap only ever lands on max again,
    // so the clamp in the next stage covers both orders of the two tests.
    always_comb begin
        priority if (i_wrap && w_above) begin
            n_hor = w_mvh - w_off;
        end else if (i_wrap && w_below) begin
            n_hor = w_mvh + w_off;
        end else begin
            n_hor = w_mvh;
        end
        n_wrap_ref = !(i_wrap && (w_above || w_below));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_hor      <= n_hor;
            r_ver      <= CW'(i_mv_ver);
            r_wrap_ref <= n_wrap_ref;
            r_hmax     <= w_hmax;
            r_hmin     <= w_hmin;
            r_vmax     <= w_vmax;
            r_vmin     <= w_vmin;
        end
    end

    assign o_valid    = r_valid;
    assign o_hor      = r_hor;
    assign o_ver      = r_ver;
    assign o_wrap_ref = r_wrap_ref;
    assign o_hmax     = r_hmax;
    assign o_hmin     = r_hmin;
    assign o_vmax     = r_vmax;
    assign o_vmin     = r_vmin;
endmodule

// ===== hw/rtl/mvc_clamp.sv =====
// Stage 3: clamp both components into the window and saturate to the output width.
module mvc_clamp #(
    parameter int CW = 25
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [CW-1:0]                 i_hor,
    input  logic signed [CW-1:0]                 i_ver,
    input  logic                                 i_wrap_ref,
    input  logic signed [CW-1:0]                 i_hmax,
    input  logic signed [CW-1:0]                 i_hmin,
    input  logic signed [CW-1:0]                 i_vmax,
    input  logic signed [CW-1:0]                 i_vmin,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mvc_pkg::MV_OUT_W-1:0]  o_mv_hor,
    output logic signed [mvc_pkg::MV_OUT_W-1:0]  o_mv_ver,
    output logic                                 o_wrap_ref
);
    import mvc_pkg::*;

    localparam logic signed [CW-1:0] SAT_HI = CW'(OUT_HI);
    localparam logic signed [CW-1:0] SAT_LO = CW'(OUT_LO);

    function automatic logic signed [MV_OUT_W-1:0] clip_sat(
        input logic signed [CW-1:0] v,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW-1:0] t;
        t = (v < lo) ? lo : v;
        t = (t > hi) ? hi : t;     // max wins when the window is empty
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return t[MV_OUT_W-1:0];
    endfunction

    logic                       r_valid;
    logic signed [MV_OUT_W-1:0] r_mv_hor, r_mv_ver;
    logic                       r_wrap_ref;
    logic                       w_adv;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_mv_hor   <= clip_sat(i_hor, i_hmin, i_hmax);
            r_mv_ver   <= clip_sat(i_ver, i_vmin, i_vmax);
            r_wrap_ref <= i_wrap_ref;
        end
    end

    assign o_valid    = r_valid;
    assign o_mv_hor   = r_mv_hor;
    assign o_mv_ver   = r_mv_ver;
    assign o_wrap_ref = r_wrap_ref;
endmodule

// ===== hw/rtl/mvc_checker.sv =====
// Port-level checker for the motion vector clipper, bound to the top level.
`include "motion_vector_clip_wrap_defines.svh"

module mvc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [mvc_pkg::MV_OUT_W-1:0]  i_out_mv_hor,
    input logic signed [mvc_pkg::MV_OUT_W-1:0]  i_out_mv_ver,
    input logic                                 i_out_wrap_ref,
    input logic                                 i_psel,
    input logic                                 i_penable,
    input logic                                 i_pwrite,
    input logic                                 i_pready,
    input logic [mvc_pkg::APB_AW-1:0]           i_paddr,
    input logic [mvc_pkg::APB_DW-1:0]           i_pwdata
);
    import mvc_pkg::*;

    // words accepted but not yet delivered; pipeline holds at most three
    logic [2:0] r_count, n_count;
    logic       r_wrap_en, n_wrap_en;
    logic       w_in_acc, w_out_acc, w_cfg_wr;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite && i_pready;

    always_comb begin
        n_count = r_count + 3'(w_in_acc) - 3'(w_out_acc);
        n_wrap_en = r_wrap_en;
        if (w_cfg_wr && (t_reg_addr'(i_paddr[APB_AW-1:2]) == REG_WRAP_ENABLE)) begin
            n_wrap_en = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wrap_en <= RST_WRAP_ENABLE;
        end else begin
            r_count   <= n_count;
            r_wrap_en <= n_wrap_en;
        end
    end

    `MVC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_mv_hor) && $stable(i_out_mv_ver) && $stable(i_out_wrap_ref), "stalled output word changed")
    `MVC_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n, i_out_valid, (r_count != 3'd0) && (r_count <= 3'd3), "output word without matching input or overfull pipeline")
    `MVC_ASSERT_NOW(a_ready_only_full, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready && (r_count == 3'd3), "input stalled while pipeline has room")
    `MVC_ASSERT_NOW(a_wrap_ref_off, i_clk, i_rst_n, i_out_valid && !r_wrap_en, i_out_wrap_ref, "wrap shift reported with wraparound disabled")
endmodule

bind motion_vector_clip_wrap mvc_checker u_mvc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_mv_hor   (o_out.out_mv_hor),
    .i_out_mv_ver   (o_out.out_mv_ver),
    .i_out_wrap_ref (o_out.wrap_ref),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_pready       (pready),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for motion_vector_clip_wrap: random and directed words, predicted clamps.
module testbench;
    import mvc_pkg::*;

    localparam int FRAC_BITS      = 4;        // matches the DUT default
    localparam int CLIP_LATENCY   = 3;        // stages from acceptance to o_out
    localparam int QUIET_LIMIT    = 2000;     // cycles with no handshake before giving up
    localparam int PHASE_WORDS    = 72;       // random words per configuration phase
    localparam int RANDOM_PHASES  = 9;
    localparam int MV_MAX         = 131071;
    localparam int MV_MIN         = -131072;
    localparam int POS_MAX        = 16383;

    // One input word, as the block sees it.
    typedef struct {
        logic signed [MV_IN_W-1:0] mv_hor;
        logic signed [MV_IN_W-1:0] mv_ver;
        logic        [POS_W-1:0]   pos_x;
        logic        [POS_W-1:0]   pos_y;
        logic        [BW_W-1:0]    block_width;
        logic                      subpic_as_pic;
        logic        [POS_W-1:0]   sub_left;
        logic        [POS_W-1:0]   sub_right;
        logic        [POS_W-1:0]   sub_top;
        logic        [POS_W-1:0]   sub_bottom;
    } t_block_desc;

    // One clipped vector.
    typedef struct {
        logic signed [MV_OUT_W-1:0] mv_hor;
        logic signed [MV_OUT_W-1:0] mv_ver;
        logic                       wrap_ref;
    } t_clip_result;

    // Scoreboard: mirror of the registers, clip predictor, queue of pending vectors.
    class clip_scoreboard;
        t_cfg         cfg;
        t_clip_result pending_clips[$];
        int           errors;
        int           words_checked;

        function new();
            cfg.pic_width   = RST_PIC_WIDTH;
            cfg.pic_height  = RST_PIC_HEIGHT;
            cfg.ctu_size    = RST_CTU_SIZE;
            cfg.wrap_enable = RST_WRAP_ENABLE;
            cfg.wrap_offset = RST_WRAP_OFFSET;
            errors = 0;
            words_checked = 0;
        endfunction

        function void set_register(t_reg_addr idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_PIC_WIDTH:   cfg.pic_width   = value[PIC_W-1:0];
                REG_PIC_HEIGHT:  cfg.pic_height  = value[PIC_W-1:0];
                REG_CTU_SIZE:    cfg.ctu_size    = value[CTU_W-1:0];
                REG_WRAP_ENABLE: cfg.wrap_enable = value[0];
                REG_WRAP_OFFSET: cfg.wrap_offset = value[PIC_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_span(longint v, longint lo, longint hi);
            longint t;
            t = (v < lo) ? lo : v;
            return (t > hi) ? hi : t;
        endfunction

        // Window edges in fractional units, then clamp; min above max yields max.
        function t_clip_result clip_vector(t_block_desc d);
            longint       s, ctu, px, py, bw, mvh, mvv, off;
            longint       hmax, hmin, vmax, vmin;
            t_clip_result r;
            s   = longint'(1) << FRAC_BITS;
            ctu = longint'(cfg.ctu_size);
            px  = longint'(d.pos_x);
            py  = longint'(d.pos_y);
            bw  = longint'(d.block_width);
            mvh = longint'(d.mv_hor);
            mvv = longint'(d.mv_ver);
            r.wrap_ref = 1'b1;
            if (cfg.wrap_enable) begin
                // subpicture bounds play no part here
                off  = longint'(cfg.wrap_offset) * s;
                hmax = (longint'(cfg.pic_width) + ctu - bw + WIN_MARGIN - px - 1) * s;
                hmin = (-ctu - WIN_MARGIN - px + 1) * s;
                vmax = (longint'(cfg.pic_height) + WIN_MARGIN - py - 1) * s;
                vmin = (-ctu - WIN_MARGIN - py + 1) * s;
                if (mvh > hmax) begin
                    mvh = clamp_span(mvh - off, hmin, hmax);
                    r.wrap_ref = 1'b0;
                end
                // tested on the shifted value: catches a clamp that landed below min
                if (mvh < hmin) begin
                    mvh = clamp_span(mvh + off, hmin, hmax);
                    r.wrap_ref = 1'b0;
                end
            end else begin
                if (d.subpic_as_pic) begin
                    hmax = (longint'(d.sub_right) + WIN_MARGIN - px) * s;
                    hmin = (-ctu - WIN_MARGIN - (px - longint'(d.sub_left)) + 1) * s;
                    vmax = (longint'(d.sub_bottom) + WIN_MARGIN - py) * s;
                    vmin = (-ctu - WIN_MARGIN - (py - longint'(d.sub_top)) + 1) * s;
                end else begin
                    hmax = (longint'(cfg.pic_width) + WIN_MARGIN - px - 1) * s;
                    hmin = (-ctu - WIN_MARGIN - px + 1) * s;
                    vmax = (longint'(cfg.pic_height) + WIN_MARGIN - py - 1) * s;
                    vmin = (-ctu - WIN_MARGIN - py + 1) * s;
                end
                mvh = clamp_span(mvh, hmin, hmax);
            end
            mvv = clamp_span(mvv, vmin, vmax);
            r.mv_hor = MV_OUT_W'(clamp_span(mvh, OUT_LO, OUT_HI));
            r.mv_ver = MV_OUT_W'(clamp_span(mvv, OUT_LO, OUT_HI));
            return r;
        endfunction

        function void note_input(t_block_desc d);
            pending_clips.push_back(clip_vector(d));
        endfunction

        function int pending();
            return pending_clips.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] word %0d: %s", $realtime, words_checked, what);
            errors++;
        endtask

        task check_result(logic signed [MV_OUT_W-1:0] hor, logic signed [MV_OUT_W-1:0] ver,
                          logic wref);
            t_clip_result exp_clip;
            if (pending_clips.size() == 0) begin
                report_mismatch("clipped vector with none pending");
            end else begin
                exp_clip = pending_clips.pop_front();
                if (hor !== exp_clip.mv_hor)
                    report_mismatch($sformatf("out_mv_hor %0d, predicted %0d",
                                              hor, exp_clip.mv_hor));
                if (ver !== exp_clip.mv_ver)
                    report_mismatch($sformatf("out_mv_ver %0d, predicted %0d",
                                              ver, exp_clip.mv_ver));
                if (wref !== exp_clip.wrap_ref)
                    report_mismatch($sformatf("wrap_ref %0b, predicted %0b",
                                              wref, exp_clip.wrap_ref));
            end
            words_checked++;
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mvc_in_if  blk_in ();
    mvc_out_if clip_out ();

    clip_scoreboard clip_sb = new();

    // Idle-free stretches, switched per phase.
    bit src_no_gaps;
    bit sink_no_stalls;

    motion_vector_clip_wrap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (blk_in),
        .o_out   (clip_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Setup then access phase, then idle with psel low so back-to-back writes never
    // lower and raise psel in the same step.
    task automatic apb_write(t_reg_addr idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        clip_sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_config(logic [APB_DW-1:0] pw, logic [APB_DW-1:0] ph,
                               logic [APB_DW-1:0] ctu, logic [APB_DW-1:0] wrap_en,
                               logic [APB_DW-1:0] off);
        apb_write(REG_PIC_WIDTH, pw);
        apb_write(REG_PIC_HEIGHT, ph);
        apb_write(REG_CTU_SIZE, ctu);
        apb_write(REG_WRAP_ENABLE, wrap_en);
        apb_write(REG_WRAP_OFFSET, off);
    endtask

    // Drop valid and hold until every pending vector has come back.
    task automatic drain_pipeline();
        blk_in.valid <= 1'b0;
        while (clip_sb.pending() != 0) @(posedge i_clk);
        repeat (CLIP_LATENCY + 1) @(posedge i_clk);
    endtask

    // Random gap, then present the word until accepted. Valid is left high so the
    // next word can follow with no bubble.
    task automatic send_word(t_block_desc d);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            blk_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_in.valid         <= 1'b1;
        blk_in.in_mv_hor     <= d.mv_hor;
        blk_in.in_mv_ver     <= d.mv_ver;
        blk_in.pos_x         <= d.pos_x;
        blk_in.pos_y         <= d.pos_y;
        blk_in.block_width   <= d.block_width;
        blk_in.subpic_as_pic <= d.subpic_as_pic;
        blk_in.sub_left      <= d.sub_left;
        blk_in.sub_right     <= d.sub_right;
        blk_in.sub_top       <= d.sub_top;
        blk_in.sub_bottom    <= d.sub_bottom;
        do @(posedge i_clk); while (blk_in.ready !== 1'b1);
        clip_sb.note_input(d);
    endtask

    function automatic t_block_desc block_desc(int mvh, int mvv, int px, int py, int bw,
                                               int sub, int bnd_l, int bnd_r,
                                               int bnd_t, int bnd_b);
        t_block_desc d;
        d.mv_hor        = MV_IN_W'(mvh);
        d.mv_ver        = MV_IN_W'(mvv);
        d.pos_x         = POS_W'(px);
        d.pos_y         = POS_W'(py);
        d.block_width   = BW_W'(bw);
        d.subpic_as_pic = sub[0];
        d.sub_left      = POS_W'(bnd_l);
        d.sub_right     = POS_W'(bnd_r);
        d.sub_top       = POS_W'(bnd_t);
        d.sub_bottom    = POS_W'(bnd_b);
        return d;
    endfunction

    // Magnitudes spread over powers of two so both window edges get hit; a few raw.
    function automatic logic signed [MV_IN_W-1:0] random_mv();
        int k;
        k = $urandom_range(2, MV_IN_W - 1);
        if ($urandom_range(0, 7) == 0)
            return MV_IN_W'($urandom);
        return MV_IN_W'(int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k));
    endfunction

    // Mostly blocks inside the picture with sane subpictures; the rest raw bits.
    function automatic t_block_desc random_desc(t_cfg c);
        t_block_desc d;
        int          lim_x, lim_y, px, py;
        lim_x = (c.pic_width  != 0 && c.pic_width  <= POS_MAX + 1) ? c.pic_width  - 1 : POS_MAX;
        lim_y = (c.pic_height != 0 && c.pic_height <= POS_MAX + 1) ? c.pic_height - 1 : POS_MAX;
        if ($urandom_range(0, 3) != 0) begin
            px = $urandom_range(0, lim_x);
            py = $urandom_range(0, lim_y);
        end else begin
            px = $urandom_range(0, POS_MAX);
            py = $urandom_range(0, POS_MAX);
        end
        d.pos_x         = POS_W'(px);
        d.pos_y         = POS_W'(py);
        d.mv_hor        = random_mv();
        d.mv_ver        = random_mv();
        d.block_width   = ($urandom_range(0, 3) != 0) ? BW_W'($urandom_range(1, 128))
                                                      : BW_W'($urandom);
        d.subpic_as_pic = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) != 0) begin
            d.sub_left   = POS_W'($urandom_range(0, px));
            d.sub_right  = POS_W'((px + $urandom_range(0, 2048) > POS_MAX) ? POS_MAX
                                  : px + $urandom_range(0, 2048));
            d.sub_top    = POS_W'($urandom_range(0, py));
            d.sub_bottom = POS_W'((py + $urandom_range(0, 2048) > POS_MAX) ? POS_MAX
                                  : py + $urandom_range(0, 2048));
        end else begin
            // inverted or stray bounds
            d.sub_left   = POS_W'($urandom);
            d.sub_right  = POS_W'($urandom);
            d.sub_top    = POS_W'($urandom);
            d.sub_bottom = POS_W'($urandom);
        end
        return d;
    endfunction

    // Result side: random stall before each word, ready kept high across words
    // when no stall is drawn.
    initial begin : result_sink
        int stall;
        clip_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_no_stalls ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                clip_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            clip_out.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(clip_out.valid === 1'b1 && clip_out.ready === 1'b1));
            clip_sb.check_result(clip_out.out_mv_hor, clip_out.out_mv_ver, clip_out.wrap_ref);
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((blk_in.valid === 1'b1 && blk_in.ready === 1'b1) ||
                (clip_out.valid === 1'b1 && clip_out.ready === 1'b1) || psel === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("motion_vector_clip_wrap regression: fail");
        $finish;
    end

    initial begin : stimulus
        int pw, ph, ctu, wrap_en, off;
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        blk_in.valid           <= 1'b0;
        blk_in.in_mv_hor       <= '0;
        blk_in.in_mv_ver       <= '0;
        blk_in.pos_x           <= '0;
        blk_in.pos_y           <= '0;
        blk_in.block_width     <= '0;
        blk_in.subpic_as_pic   <= 1'b0;
        blk_in.sub_left        <= '0;
        blk_in.sub_right       <= '0;
        blk_in.sub_top         <= '0;
        blk_in.sub_bottom      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: plain picture window, HD defaults
        load_config(1920, 1080, 128, 0, 0);
        send_word(block_desc(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MAX, MV_MAX, 0, 0, 1, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MIN, MV_MIN, 0, 0, 1, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MAX, MV_MAX, POS_MAX, POS_MAX, 128, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MIN, MV_MIN, POS_MAX, POS_MAX, 128, 0, 0, 0, 0, 0));
        // subpicture window
        send_word(block_desc(MV_MAX, MV_MAX, 300, 200, 16, 1, 256, 767, 128, 511));
        send_word(block_desc(MV_MIN, MV_MIN, 300, 200, 16, 1, 256, 767, 128, 511));
        // inverted subpicture: min above max, clamp gives max
        send_word(block_desc(0, 0, 0, 0, 8, 1, POS_MAX, 0, POS_MAX, 0));
        send_word(block_desc(MV_MAX, MV_MIN, 0, 0, 8, 1, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        drain_pipeline();

        // --- directed: wraparound on, subpictures must be ignored
        load_config(1920, 1080, 128, 1, 1920);
        send_word(block_desc(MV_MAX, 0, 0, 0, 8, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MIN, 0, 0, 0, 8, 0, 0, 0, 0, 0));
        send_word(block_desc(100, -100, 960, 540, 32, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MAX, MV_MAX, 300, 200, 16, 1, 256, 767, 128, 511));
        send_word(block_desc(20000, 0, 1000, 500, 16, 0, 0, 0, 0, 0));
        send_word(block_desc(-25000, 0, 1000, 500, 255, 1, 0, 0, 0, 0));
        send_word(block_desc(MV_MAX, 0, 1000, 500, 0, 0, 0, 0, 0, 0));
        drain_pipeline();

        // --- directed: smallest picture and CTU, widest offset; wide block puts min
        // above max so the shifted value falls under min and is shifted back
        load_config(8, 8, 16, 1, 16384);
        send_word(block_desc(0, 0, 0, 0, 255, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MAX, MV_MAX, POS_MAX, POS_MAX, 1, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MIN, MV_MIN, POS_MAX, POS_MAX, 128, 1, 5, 9, 5, 9));
        drain_pipeline();

        // --- directed: largest picture, wrap off
        load_config(16384, 16384, 128, 0, 16384);
        send_word(block_desc(MV_MAX, MV_MAX, POS_MAX, POS_MAX, 128, 0, 0, 0, 0, 0));
        send_word(block_desc(MV_MIN, MV_MIN, 0, 0, 1, 1, 0, POS_MAX, 0, POS_MAX));
        drain_pipeline();

        // --- random phases over a spread of register settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pw      = $urandom_range(8, 16384);
            ph      = $urandom_range(8, 16384);
            ctu     = 16 << $urandom_range(0, 3);
            wrap_en = 0;
            off     = 0;
            case (p)
                1: begin
                    wrap_en = 1;
                    off     = $urandom_range(0, 16384);
                end
                2: begin
                    pw  = 8;
                    ph  = 8;
                    ctu = 16;
                end
                3: begin
                    pw      = 16384;
                    ph      = 16384;
                    ctu     = 128;
                    wrap_en = 1;
                    off     = 16384;
                end
                4: begin
                    pw      = 8;
                    ph      = 16384;
                    ctu     = 16;
                    wrap_en = 1;   // zero offset: flag still drops
                end
                5: begin
                    ctu     = $urandom_range(16, 128);
                    wrap_en = 1;
                    off     = pw;
                end
                6: begin
                    // whole register width, stray bits included
                    pw      = $urandom;
                    ph      = $urandom;
                    ctu     = $urandom;
                    wrap_en = $urandom;
                    off     = $urandom;
                end
                8: begin
                    pw      = $urandom;
                    ph      = $urandom;
                    ctu     = $urandom;
                    wrap_en = 1;
                    off     = $urandom;
                end
                default: ;
            endcase
            src_no_gaps    = (p == 3 || p == 7);
            sink_no_stalls = (p == 4 || p == 7);
            load_config(pw, ph, ctu, wrap_en, off);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_desc(clip_sb.cfg));
                // occasional full drain mid-phase
                if ($urandom_range(0, 63) == 0)
                    drain_pipeline();
            end
            drain_pipeline();
        end

        if (clip_sb.errors == 0)
            $display("motion_vector_clip_wrap regression: pass");
        else
            $display("motion_vector_clip_wrap regression: fail");
        $finish;
    end

endmodule

// ===== motion_vector_clip_wrap.f =====
+incdir+hw/rtl
hw/rtl/mvc_pkg.sv
hw/rtl/mvc_if.sv
hw/rtl/mvc_cfg.sv
hw/rtl/mvc_bound.sv
hw/rtl/mvc_wrap.sv
hw/rtl/mvc_clamp.sv
hw/rtl/motion_vector_clip_wrap.sv
hw/rtl/mvc_checker.sv
verif/testbench.sv
